// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== hdl/dlr_pkg.sv =====
`timescale 1ns / 1ps

package dlr_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  // accumulator: sign, COORD_BITS+1 integer bits less sign, FRAC_BITS fraction
  localparam int POS_W = COORD_BITS + FRAC_BITS + 1;
  // increment: signed Q1.FRAC_BITS
  localparam int INC_W = FRAC_BITS + 2;
  // quotient magnitude, at most 1.0
  localparam int QUO_W = FRAC_BITS + 1;
  // dividend |d| << FRAC_BITS
  localparam int DVD_W = COORD_BITS + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int RND_W = POS_W + 1;

  typedef enum logic [1:0] {
    ST_READY,
    ST_DIV_X,
    ST_DIV_Y
  } seq_state_t;

  typedef enum logic {
    REQ_LINE    = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_type_t;

  // round half up, then clamp into the coordinate range
  function automatic logic [COORD_BITS-1:0] round_coord(input logic [POS_W-1:0] pos);
    logic [RND_W-1:0] r;
    logic [COORD_BITS-1:0] v;
    r = {pos[POS_W-1], pos} + (RND_W'(1) << (FRAC_BITS - 1));
    if (r[RND_W-1]) begin
      v = '0;
    end else if (r[RND_W-2]) begin
      v = '1;
    end else begin
      v = r[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
    end
    return v;
  endfunction

endpackage

// ===== hdl/dda_line_rasterizer_top.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  req_type, start_x, start_y, end_x, end_y
// out_      output     out_valid / out_stall point_x, point_y, last_point
//
// a new-line transaction puts its start point in the output register on the next cycle
// and, unless it is zero length, in_stall then stays high while one shared restoring
// divider finds the x then the y increment
// an advance is taken every cycle unless stalled and gives its point on the next cycle
// rst_n is synchronous and active low; after it the block is idle with no line
// a stalled output register holds its point and also holds off the input side

module dda_line_rasterizer_top
  import dlr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_point_x,
  output logic [COORD_BITS-1:0] out_point_y,
  output logic                  out_last_point
);

  `include "assert_macros.svh"

  // sequencer
  seq_state_t state_r, state_nxt;

  // line state
  logic                  line_busy_r, line_busy_nxt;
  logic [POS_W-1:0]      pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]      pos_y_r, pos_y_nxt;
  logic [INC_W-1:0]      inc_x_r, inc_x_nxt;
  logic [INC_W-1:0]      inc_y_r, inc_y_nxt;
  logic [COORD_BITS-1:0] steps_left_r, steps_left_nxt;

  // divider operands and working registers
  logic [COORD_BITS-1:0] steps_r, steps_nxt;
  logic [COORD_BITS-1:0] ay_r, ay_nxt;
  logic                  neg_x_r, neg_x_nxt;
  logic                  neg_y_r, neg_y_nxt;
  logic [DVD_W-1:0]      dvd_r, dvd_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] out_x_r, out_x_nxt;
  logic [COORD_BITS-1:0] out_y_r, out_y_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_accept;
  logic                  out_free;
  logic                  div_active;

  // new-line set-up
  logic                  dx_neg, dy_neg;
  logic [COORD_BITS-1:0] ax, ay, steps;

  // shared divider step
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS+1:0] diff;
  logic                  q_bit;
  logic [COORD_BITS-1:0] rem_step;
  logic [DVD_W-1:0]      dvd_step;
  logic [QUO_W-1:0]      quot;
  logic [INC_W-1:0]      inc_signed;

  // advance
  logic [POS_W-1:0]      adv_x, adv_y;
  logic [COORD_BITS-1:0] adv_steps;

  // output slot is free when empty or drained in this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_accept = in_valid && !in_stall;

  // endpoint differences and major-axis length
  assign dx_neg = in_end_x < in_start_x;
  assign dy_neg = in_end_y < in_start_y;
  assign ax     = dx_neg ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
  assign ay     = dy_neg ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
  assign steps  = (ax > ay) ? ax : ay;

  // one restoring step: shift in the next dividend bit, try to subtract the divisor
  assign trial    = {rem_r, dvd_r[DVD_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, steps_r};
  assign q_bit    = !diff[COORD_BITS+1];
  assign rem_step = q_bit ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
  assign dvd_step = {dvd_r[DVD_W-2:0], q_bit};
  // quotient never exceeds 1.0, so only the low bits matter
  assign quot     = dvd_step[QUO_W-1:0];

  always_comb begin
    if ((state_r == ST_DIV_X) ? neg_x_r : neg_y_r) begin
      inc_signed = INC_W'(0) - INC_W'({1'b0, quot});
    end else begin
      inc_signed = INC_W'({1'b0, quot});
    end
  end

  // accumulator update for an advance
  assign adv_x     = pos_x_r + {{(POS_W-INC_W){inc_x_r[INC_W-1]}}, inc_x_r};
  assign adv_y     = pos_y_r + {{(POS_W-INC_W){inc_y_r[INC_W-1]}}, inc_y_r};
  assign adv_steps = steps_left_r - COORD_BITS'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_READY: begin
        if (in_accept && (in_req_type == REQ_LINE) && (steps != '0)) begin
          state_nxt = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (cnt_r == '0) begin
          state_nxt = ST_READY;
        end
      end
      default: state_nxt = ST_READY;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_active = 1'b0;
    case (state_r)
      ST_READY: div_active = 1'b0;
      ST_DIV_X: div_active = 1'b1;
      ST_DIV_Y: div_active = 1'b1;
      default:  div_active = 1'b0;
    endcase
    in_stall = div_active || !out_free;
  end

  // datapath next values
  always_comb begin
    line_busy_nxt  = line_busy_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    inc_x_nxt      = inc_x_r;
    inc_y_nxt      = inc_y_r;
    steps_left_nxt = steps_left_r;
    steps_nxt      = steps_r;
    ay_nxt         = ay_r;
    neg_x_nxt      = neg_x_r;
    neg_y_nxt      = neg_y_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_last_nxt   = out_last_r;

    if (div_active) begin
      dvd_nxt = dvd_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        if (state_r == ST_DIV_X) begin
          inc_x_nxt = inc_signed;
          // reload the divider with the y magnitude
          dvd_nxt   = {ay_r, {FRAC_BITS{1'b0}}};
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(DVD_W - 1);
        end else begin
          inc_y_nxt = inc_signed;
        end
      end
    end else if (in_accept) begin
      if (in_req_type == REQ_LINE) begin
        // start point goes out at once; a zero-length line ends here
        pos_x_nxt      = {1'b0, in_start_x, {FRAC_BITS{1'b0}}};
        pos_y_nxt      = {1'b0, in_start_y, {FRAC_BITS{1'b0}}};
        inc_x_nxt      = '0;
        inc_y_nxt      = '0;
        steps_left_nxt = steps;
        line_busy_nxt  = steps != '0;
        steps_nxt      = steps;
        ay_nxt         = ay;
        neg_x_nxt      = dx_neg;
        neg_y_nxt      = dy_neg;
        dvd_nxt        = {ax, {FRAC_BITS{1'b0}}};
        rem_nxt        = '0;
        cnt_nxt        = CNT_W'(DVD_W - 1);
        out_valid_nxt  = 1'b1;
        out_x_nxt      = in_start_x;
        out_y_nxt      = in_start_y;
        out_last_nxt   = steps == '0;
      end else if (line_busy_r) begin
        pos_x_nxt      = adv_x;
        pos_y_nxt      = adv_y;
        steps_left_nxt = adv_steps;
        line_busy_nxt  = adv_steps != '0;
        out_valid_nxt  = 1'b1;
        out_x_nxt      = round_coord(adv_x);
        out_y_nxt      = round_coord(adv_y);
        out_last_nxt   = adv_steps == '0;
      end
      // an advance with no line in progress is simply dropped
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_READY;
      line_busy_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      inc_x_r      <= '0;
      inc_y_r      <= '0;
      steps_left_r <= '0;
    end else begin
      state_r      <= state_nxt;
      line_busy_r  <= line_busy_nxt;
      out_valid_r  <= out_valid_nxt;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      inc_x_r      <= inc_x_nxt;
      inc_y_r      <= inc_y_nxt;
      steps_left_r <= steps_left_nxt;
    end
  end

  // payload and divider working registers need no reset
  always_ff @(posedge clk) begin
    steps_r    <= steps_nxt;
    ay_r       <= ay_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_last_point = out_last_r;

  // no transaction may slip in while the divider is busy
  `ASSERT_NEVER(a_no_accept_in_div, clk, rst_n, div_active && in_accept, "input taken during division")
  // a fresh result only follows an accepted transaction
  `ASSERT_HOLDS(a_out_from_accept, clk, rst_n, $rose(out_valid_r) |-> $past(in_accept), "result without transaction")
  // x division hands over to y division
  `ASSERT_HOLDS(a_div_x_to_y, clk, rst_n, (state_r == ST_DIV_X && cnt_r == '0) |=> (state_r == ST_DIV_Y), "divider sequence broken")
  // a live line always has points left
  `ASSERT_NEVER(a_busy_has_steps, clk, rst_n, line_busy_r && (steps_left_r == '0), "live line with no steps left")

endmodule
